// ===== hdl/qtu_pkg.sv =====
// ----------------------------------------------------------------------------
// qtu_pkg
// Sizes, widths and register codes shared by the Q table update block.
// ----------------------------------------------------------------------------
package qtu_pkg;

  // table shape
  localparam int NUM_STATES  = 16;
  localparam int NUM_ACTIONS = 4;
  localparam int TABLE_SIZE  = NUM_STATES * NUM_ACTIONS;

  // derived widths
  localparam int STATE_W  = $clog2(NUM_STATES);
  localparam int ACTION_W = $clog2(NUM_ACTIONS);
  localparam int ADDR_W   = $clog2(TABLE_SIZE);
  localparam int CNT_W    = $clog2(NUM_ACTIONS + 1);

  // fixed field widths of the beats
  localparam int STATE_IN_W  = 4;
  localparam int ACTION_IN_W = 2;
  localparam int VALUE_W     = 32;
  localparam int FRAC_W      = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register codes
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_GAMMA = 1'b1;

  // register reset values
  localparam logic [FRAC_W-1:0] ALPHA_RESET = 16'd6554;
  localparam logic [FRAC_W-1:0] GAMMA_RESET = 16'd58982;

endpackage

// ===== hdl/q_table_update_top.sv =====
// ----------------------------------------------------------------------------
// q_table_update_top
// One tabular Q-learning step per input beat, table held in a synchronous
// RAM with one read and one write port and a valid bit per entry.
// Beats are taken one at a time: in_ready stays low until the write back
// of the last beat is done, and the single RAM read port reads the next
// row and the updated entry in turn.
// Reset: all Q entries read as zero, alpha and gamma return to their defaults.
// ----------------------------------------------------------------------------
module q_table_update_top
  import qtu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [STATE_IN_W-1:0]      current_state,
  input  logic [ACTION_IN_W-1:0]     chosen_action,
  input  logic signed [VALUE_W-1:0]  reward_value,
  input  logic [STATE_IN_W-1:0]      following_state,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  updated_value,
  output logic                       saturated
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_MUL1  = 6'b001000,
    ST_TD    = 6'b010000,
    ST_MUL2  = 6'b100000
  } ctrl_state_t;

  // write back shares the last step with the second product
  ctrl_state_t state, state_next;
  logic        wb_pend;

  // configuration registers
  logic [FRAC_W-1:0] alpha;
  logic [FRAC_W-1:0] discount_factor;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha           <= ALPHA_RESET;
      discount_factor <= GAMMA_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ALPHA: alpha           <= pwdata[FRAC_W-1:0];
        REG_GAMMA: discount_factor <= pwdata[FRAC_W-1:0];
        default:   ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_ALPHA: prdata = PDATA_W'(alpha);
      REG_GAMMA: prdata = PDATA_W'(discount_factor);
      default:   prdata = '0;
    endcase
  end

  // latched beat fields
  logic [ADDR_W-1:0]         cur_addr;
  logic [ADDR_W-1:0]         row_base;
  logic signed [VALUE_W-1:0] reward;
  logic [STATE_W-1:0]        s_idx;
  logic [STATE_W-1:0]        ns_idx;
  logic [ACTION_W-1:0]       a_idx;
  logic                      accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;

  assign s_idx  = STATE_W'(current_state % NUM_STATES);
  assign ns_idx = STATE_W'(following_state % NUM_STATES);
  assign a_idx  = ACTION_W'(chosen_action % NUM_ACTIONS);

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_addr <= ADDR_W'(int'(s_idx) * NUM_ACTIONS + int'(a_idx));
      row_base <= ADDR_W'(int'(ns_idx) * NUM_ACTIONS);
      reward   <= reward_value;
    end
  end

  // read sequencing: row entries first, then the entry being updated
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_pend;
  logic [CNT_W-1:0]  rd_tag;
  logic              last_read;

  assign last_read = (cnt == CNT_W'(NUM_ACTIONS));
  assign rd_addr   = last_read ? cur_addr : ADDR_W'(int'(row_base) + int'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == ST_READ);
      if (state == ST_READ) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= cnt;
  end

  // table memory with valid bits
  logic [VALUE_W-1:0]    mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vbits;
  logic [VALUE_W-1:0]    rd_data;
  logic                  rd_vbit;
  logic                  mem_we;
  logic signed [VALUE_W-1:0] nv_sat;
  logic signed [VALUE_W-1:0] rd_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_addr] <= nv_sat;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (mem_we) begin
      vbits[cur_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vbit <= vbits[rd_addr];
  end

  assign rd_val = rd_vbit ? $signed(rd_data) : '0;

  // running maximum over the row and capture of the old value
  logic signed [VALUE_W-1:0] best;
  logic signed [VALUE_W-1:0] q_old;

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (rd_tag == CNT_W'(NUM_ACTIONS)) begin
        q_old <= rd_val;
      end else if (rd_tag == '0 || rd_val > best) begin
        best <= rd_val;
      end
    end
  end

  // gamma * max
  localparam int P1_W = FRAC_W + 1 + VALUE_W;
  localparam int GM_W = P1_W - FRAC_W;
  localparam int TD_W = VALUE_W + 2;
  localparam int P2_W = FRAC_W + 1 + TD_W;
  localparam int DL_W = P2_W - FRAC_W;
  localparam int NV_W = DL_W + 1;

  logic signed [P1_W-1:0] prod1;
  logic signed [P1_W-1:0] prod1_rnd;
  logic signed [GM_W-1:0] gm;

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      prod1 <= $signed({1'b0, discount_factor}) * best;
    end
  end

  assign prod1_rnd = prod1 + P1_W'(signed'(1 << (FRAC_W - 1)));
  assign gm        = prod1_rnd[P1_W-1:FRAC_W];

  // temporal difference
  logic signed [TD_W-1:0] td;

  always_ff @(posedge clk) begin
    if (state == ST_TD) begin
      td <= TD_W'(reward) + TD_W'(gm) - TD_W'(q_old);
    end
  end

  // alpha * td
  logic signed [P2_W-1:0] prod2;
  logic signed [P2_W-1:0] prod2_rnd;
  logic signed [DL_W-1:0] delta;
  logic signed [NV_W-1:0] nv;
  logic                   nv_ovf;

  always_ff @(posedge clk) begin
    if (state == ST_MUL2) begin
      prod2 <= $signed({1'b0, alpha}) * td;
    end
  end

  assign prod2_rnd = prod2 + P2_W'(signed'(1 << (FRAC_W - 1)));
  assign delta     = prod2_rnd[P2_W-1:FRAC_W];
  assign nv        = NV_W'(q_old) + NV_W'(delta);

  // clip to 32 bits
  assign nv_ovf = (nv[NV_W-1:VALUE_W-1] != '0) && (nv[NV_W-1:VALUE_W-1] != '1);

  always_comb begin
    priority if (!nv_ovf) begin
      nv_sat = nv[VALUE_W-1:0];
    end else if (nv[NV_W-1]) begin
      nv_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      nv_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // write back once the output register is free
  assign mem_we = wb_pend & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mem_we) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      updated_value <= nv_sat;
      saturated     <= nv_ovf;
    end
  end

  // control sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  if (last_read) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_TD;
      ST_TD:    state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // write back stage holds the next beat off until it completes
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wb_pend <= 1'b0;
    end else begin
      if (wb_pend) begin
        if (mem_we) begin
          state   <= ST_IDLE;
          wb_pend <= 1'b0;
        end
      end else if (state == ST_MUL2) begin
        wb_pend <= 1'b1;
        state   <= ST_MUL2;
      end else begin
        state <= state_next;
      end
    end
  end

  // checks
  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    wb_pend |-> !in_ready)
    else $error("input beat taken while a write back is pending");

  a_out_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(mem_we))
    else $error("result beat raised without a write back");

  a_written_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> vbits[$past(cur_addr)])
    else $error("written entry not marked valid");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (updated_value == {1'b1, {(VALUE_W-1){1'b0}}} ||
       updated_value == {1'b0, {(VALUE_W-1){1'b1}}}))
    else $error("clipped result is not a bound");

  a_reads_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !rd_pend)
    else $error("memory read outstanding while idle");

endmodule
